FILE: rtl/tfn_pkg.sv
// Shared types and constants for the triangle face normal unit.
package tfn_pkg;

  // Register index of min_length on the configuration port.
  localparam logic [1:0] REG_MIN_LENGTH = 2'd0;
  localparam logic [15:0] MIN_LENGTH_RESET = 16'd7;

  // Unit length in Q1.14.
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // Pipeline depths of the three sections.
  localparam int unsigned FrontStages = 8;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned Latency = FrontStages + SqrtSteps + DivSteps + 1;

  // One triangle as it enters the block.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_coord;
    logic signed [31:0] bz;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic batch_end;
  } tfn_item_t;

  // One normal as it leaves the block.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic degenerate;
    logic last_out;
  } tfn_result_t;

  // Per-triangle data that rides along the cell chains.
  typedef struct packed {
    logic last;
    logic degen;
    logic [2:0] neg;
    logic [2:0][30:0] m;
  } tfn_lane_t;

  // Working state of one square root step.
  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } tfn_sqrt_t;

  // Working state of one division step, three components in parallel.
  typedef struct packed {
    logic [31:0] len;
    logic [2:0][32:0] r;
    logic [2:0][15:0] q;
  } tfn_div_t;

endpackage

FILE: rtl/tfn_front.sv
// Front pipeline: edges, cross product, magnitude, degeneracy test and sum of squares.
module tfn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tfn_pkg::tfn_item_t   item_i,
  input  logic [15:0]          min_length_i,
  output logic                 valid_o,
  output tfn_pkg::tfn_lane_t   lane_o,
  output logic [63:0]          sum_o
);

  logic [tfn_pkg::FrontStages-1:0] vld_q;
  logic [tfn_pkg::FrontStages-1:0] last_q;

  // Stage 1 registers: edge vectors.
  logic signed [2:0][32:0] e1_q, e2_q;
  // Stage 2: the six partial products.
  logic signed [2:0][65:0] pa_q, pb_q;
  // Stage 3: signed cross product.
  logic signed [2:0][66:0] cr_q;
  // Stage 4 onward: magnitudes and signs.
  logic [2:0][65:0] mag4_q, mag5_q;
  logic [2:0] neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  // Stage 5: shift amount, flags and low-word squares.
  logic [5:0] shamt5_q;
  logic zero5_q, small5_q;
  logic [2:0][63:0] sqd5_q;
  logic [31:0] thr5_q;
  // Stage 6 to 8.
  logic [2:0][30:0] m6_q, m7_q, m8_q;
  logic degen6_q, degen7_q, degen8_q;
  logic [2:0][61:0] msq7_q;
  logic [63:0] sum8_q;

  logic signed [2:0][32:0] e1_d, e2_d;
  logic [65:0] or4;
  logic [6:0] blen;
  logic [5:0] shamt_d;
  logic [2:0] neg_d;
  logic [2:0][65:0] mag_d;
  logic [65:0] dsum;

  // Edge vectors at 33 bits, exact.
  always_comb begin
    e1_d[0] = {item_i.bx[31], item_i.bx} - {item_i.ax[31], item_i.ax};
    e1_d[1] = {item_i.by_coord[31], item_i.by_coord} - {item_i.ay[31], item_i.ay};
    e1_d[2] = {item_i.bz[31], item_i.bz} - {item_i.az[31], item_i.az};
    e2_d[0] = {item_i.cx[31], item_i.cx} - {item_i.ax[31], item_i.ax};
    e2_d[1] = {item_i.cy[31], item_i.cy} - {item_i.ay[31], item_i.ay};
    e2_d[2] = {item_i.cz[31], item_i.cz} - {item_i.az[31], item_i.az};
  end

  // Absolute value of each cross component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = cr_q[i][66];
      mag_d[i] = neg_d[i] ? 66'(-cr_q[i]) : 66'(cr_q[i]);
    end
  end

  // Bit length of the largest magnitude sets the normalizing shift.
  always_comb begin
    or4 = mag4_q[0] | mag4_q[1] | mag4_q[2];
    blen = '0;
    for (int i = 0; i < 66; i++) begin
      if (or4[i]) blen = 7'(i + 1);
    end
    shamt_d = (blen > 7'd31) ? 6'(blen - 7'd31) : 6'd0;
  end

  // Exact sum of squares for the degeneracy test, valid when all are small.
  assign dsum = 66'(sqd5_q[0]) + 66'(sqd5_q[1]) + 66'(sqd5_q[2]);

  // Valid pipeline; the batch marker moves with the datapath registers below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[tfn_pkg::FrontStages-2:0], valid_i};
    end
  end

  // Datapath registers; elements of the packed arrays are read back as signed.
  always_ff @(posedge clk_i) begin
    last_q <= {last_q[tfn_pkg::FrontStages-2:0], item_i.batch_end};
    e1_q <= e1_d;
    e2_q <= e2_d;
    pa_q[0] <= $signed(e1_q[1]) * $signed(e2_q[2]);
    pb_q[0] <= $signed(e1_q[2]) * $signed(e2_q[1]);
    pa_q[1] <= $signed(e1_q[2]) * $signed(e2_q[0]);
    pb_q[1] <= $signed(e1_q[0]) * $signed(e2_q[2]);
    pa_q[2] <= $signed(e1_q[0]) * $signed(e2_q[1]);
    pb_q[2] <= $signed(e1_q[1]) * $signed(e2_q[0]);
    for (int i = 0; i < 3; i++) begin
      cr_q[i] <= 67'($signed(pa_q[i])) - 67'($signed(pb_q[i]));
    end
    mag4_q <= mag_d;
    neg4_q <= neg_d;
    mag5_q <= mag4_q;
    neg5_q <= neg4_q;
    shamt5_q <= shamt_d;
    zero5_q <= (or4 == '0);
    small5_q <= (or4[65:32] == '0);
    for (int i = 0; i < 3; i++) begin
      sqd5_q[i] <= mag4_q[i][31:0] * mag4_q[i][31:0];
    end
    thr5_q <= min_length_i * min_length_i;
    for (int i = 0; i < 3; i++) begin
      m6_q[i] <= 31'(mag5_q[i] >> shamt5_q);
    end
    neg6_q <= neg5_q;
    degen6_q <= zero5_q | (small5_q & (dsum < {2'b00, thr5_q, 32'd0}));
    m7_q <= m6_q;
    neg7_q <= neg6_q;
    degen7_q <= degen6_q;
    for (int i = 0; i < 3; i++) begin
      msq7_q[i] <= m6_q[i] * m6_q[i];
    end
    m8_q <= m7_q;
    neg8_q <= neg7_q;
    degen8_q <= degen7_q;
    sum8_q <= 64'(msq7_q[0]) + 64'(msq7_q[1]) + 64'(msq7_q[2]);
  end

  assign valid_o = vld_q[tfn_pkg::FrontStages-1];
  assign lane_o.last = last_q[tfn_pkg::FrontStages-1];
  assign lane_o.degen = degen8_q;
  assign lane_o.neg = neg8_q;
  assign lane_o.m = m8_q;
  assign sum_o = sum8_q;

endmodule

FILE: rtl/tfn_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per cell.
module tfn_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tfn_pkg::tfn_lane_t lane_i,
  input  tfn_pkg::tfn_sqrt_t st_i,
  output logic               valid_o,
  output tfn_pkg::tfn_lane_t lane_o,
  output tfn_pkg::tfn_sqrt_t st_o
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  logic valid_q;
  tfn_pkg::tfn_lane_t lane_q;
  tfn_pkg::tfn_sqrt_t st_q, st_d;
  logic [63:0] trial;

  // Restoring step: take the bit when the remainder allows it.
  always_comb begin
    trial = st_i.res + Bit;
    if (st_i.n >= trial) begin
      st_d.n = st_i.n - trial;
      st_d.res = (st_i.res >> 1) + Bit;
    end else begin
      st_d.n = st_i.n;
      st_d.res = st_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_i;
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign lane_o = lane_q;
  assign st_o = st_q;

endmodule

FILE: rtl/tfn_div_cell.sv
// One cell of the division chain: one quotient bit for each of the three components.
module tfn_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tfn_pkg::tfn_lane_t lane_i,
  input  tfn_pkg::tfn_div_t  st_i,
  output logic               valid_o,
  output tfn_pkg::tfn_lane_t lane_o,
  output tfn_pkg::tfn_div_t  st_o
);

  logic valid_q;
  tfn_pkg::tfn_lane_t lane_q;
  tfn_pkg::tfn_div_t st_q, st_d;
  logic [32:0] rem;
  logic take;

  // Compare, subtract, then double the remainder for the next bit.
  always_comb begin
    st_d.len = st_i.len;
    rem = '0;
    take = 1'b0;
    for (int i = 0; i < 3; i++) begin
      take = (st_i.r[i] >= {1'b0, st_i.len});
      rem = take ? (st_i.r[i] - {1'b0, st_i.len}) : st_i.r[i];
      st_d.r[i] = {rem[31:0], 1'b0};
      st_d.q[i] = {st_i.q[i][14:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_i;
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign lane_o = lane_q;
  assign st_o = st_q;

endmodule

FILE: rtl/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: config register, cell chains and output stage.
// Path: a transferred triangle passes through 8 front stages, 32 square root cells,
// 16 division cells and 1 output register before its result appears.
// Throughput: one triangle per cycle; busy never rises and the receiver cannot stall.
// Reset clears all valid bits and sets min_length to 7; in-flight triangles are dropped.
module triangle_face_normal_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tfn_pkg::tfn_item_t    item_i,
  output logic                  done_o,
  output tfn_pkg::tfn_result_t  result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned NS = tfn_pkg::SqrtSteps;
  localparam int unsigned ND = tfn_pkg::DivSteps;

  logic [15:0] min_length_q;
  logic cfg_wr;

  logic front_vld;
  tfn_pkg::tfn_lane_t front_lane;
  logic [63:0] front_sum;

  logic [NS:0] sq_vld;
  tfn_pkg::tfn_lane_t sq_lane [NS+1];
  tfn_pkg::tfn_sqrt_t sq_st [NS+1];

  logic [ND:0] dv_vld;
  tfn_pkg::tfn_lane_t dv_lane [ND+1];
  tfn_pkg::tfn_div_t dv_st [ND+1];
  tfn_pkg::tfn_div_t dv_init;

  logic done_q;
  tfn_pkg::tfn_result_t res_q, res_d;
  logic [16:0] rnd;
  logic [15:0] mag;

  // Configuration port: one register, writes only to its aligned address.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == tfn_pkg::REG_MIN_LENGTH);
  assign prdata = (paddr == tfn_pkg::REG_MIN_LENGTH) ? {16'd0, min_length_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= tfn_pkg::MIN_LENGTH_RESET;
    end else if (cfg_wr) begin
      min_length_q <= pwdata[15:0];
    end
  end

  assign busy = 1'b0;

  tfn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start & ~busy),
    .item_i       (item_i),
    .min_length_i (min_length_q),
    .valid_o      (front_vld),
    .lane_o       (front_lane),
    .sum_o        (front_sum)
  );

  // Square root chain.
  assign sq_vld[0] = front_vld;
  assign sq_lane[0] = front_lane;
  assign sq_st[0] = '{n: front_sum, res: 64'd0};

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    tfn_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[k]),
      .lane_i  (sq_lane[k]),
      .st_i    (sq_st[k]),
      .valid_o (sq_vld[k+1]),
      .lane_o  (sq_lane[k+1]),
      .st_o    (sq_st[k+1])
    );
  end

  // Division chain starts from the shifted magnitudes and the length.
  always_comb begin
    dv_init.len = (sq_st[NS].res[31:0] == '0) ? 32'd1 : sq_st[NS].res[31:0];
    for (int i = 0; i < 3; i++) begin
      dv_init.r[i] = {2'b00, sq_lane[NS].m[i]};
      dv_init.q[i] = '0;
    end
  end
  assign dv_st[0] = dv_init;
  assign dv_vld[0] = sq_vld[NS];
  assign dv_lane[0] = sq_lane[NS];

  for (genvar k = 0; k < ND; k++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_vld[k]),
      .lane_i  (dv_lane[k]),
      .st_i    (dv_st[k]),
      .valid_o (dv_vld[k+1]),
      .lane_o  (dv_lane[k+1]),
      .st_o    (dv_st[k+1])
    );
  end

  // Round to nearest, clamp, apply sign, or give the fallback normal.
  always_comb begin
    res_d.degenerate = dv_lane[ND].degen;
    res_d.last_out = dv_lane[ND].last;
    res_d.nx = '0;
    res_d.ny = '0;
    res_d.nz = '0;
    rnd = '0;
    mag = '0;
    if (dv_lane[ND].degen) begin
      res_d.nz = tfn_pkg::ONE_Q14;
    end else begin
      for (int i = 0; i < 3; i++) begin
        rnd = (17'(dv_st[ND].q[i]) + 17'd1) >> 1;
        mag = (rnd > 17'(tfn_pkg::ONE_Q14)) ? tfn_pkg::ONE_Q14 : rnd[15:0];
        if (dv_lane[ND].neg[i]) mag = 16'(-mag);
        case (i)
          0: res_d.nx = mag;
          1: res_d.ny = mag;
          default: res_d.nz = mag;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign result_o = res_q;

  // A result only appears for an earlier input transfer.
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start & ~busy, tfn_pkg::Latency))
    else $error("result without a matching input transfer");

  // A degenerate result always carries the fallback normal.
  a_degen_fallback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      result_o.nx == 16'sd0 && result_o.ny == 16'sd0 && result_o.nz == 16'sd16384)
    else $error("degenerate result with wrong normal");

  // The x and z normal components stay within unit range.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.nx >= -16'sd16384 && result_o.nx <= 16'sd16384 &&
               result_o.nz >= -16'sd16384 && result_o.nz <= 16'sd16384)
    else $error("normal component out of range");

endmodule

FILE: verif/tb_triangle_face_normal_unit.sv
// Testbench for the triangle face normal unit: random and directed triangles against a predictor.
module tb_triangle_face_normal_unit;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems = 1300;

  // Scoreboard that holds the expected normals in transfer order.
  class normal_scoreboard;
    tfn_pkg::tfn_result_t pending[$];
    int unsigned failures;

    function void note_triangle(tfn_pkg::tfn_result_t exp_res);
      pending = {pending, exp_res};
    endfunction

    function void check_normal(tfn_pkg::tfn_result_t act);
      tfn_pkg::tfn_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result nx=%0d ny=%0d nz=%0d", act.nx, act.ny, act.nz);
        failures++;
        return;
      end
      exp_res = pending.pop_front();
      if (act.nx !== exp_res.nx) begin
        $error("nx expected %0d actual %0d", exp_res.nx, act.nx);
        failures++;
      end
      if (act.ny !== exp_res.ny) begin
        $error("ny expected %0d actual %0d", exp_res.ny, act.ny);
        failures++;
      end
      if (act.nz !== exp_res.nz) begin
        $error("nz expected %0d actual %0d", exp_res.nz, act.nz);
        failures++;
      end
      if (act.degenerate !== exp_res.degenerate) begin
        $error("degenerate expected %0b actual %0b", exp_res.degenerate, act.degenerate);
        failures++;
      end
      if (act.last_out !== exp_res.last_out) begin
        $error("last_out expected %0b actual %0b", exp_res.last_out, act.last_out);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  tfn_pkg::tfn_item_t item_i = '0;
  logic done_o;
  tfn_pkg::tfn_result_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  normal_scoreboard board = new();
  logic [15:0] min_len_q = tfn_pkg::MIN_LENGTH_RESET;
  int unsigned idle_cycles;
  bit timed_out;

  triangle_face_normal_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Expected normal of one triangle under the current minimum length.
  function automatic tfn_pkg::tfn_result_t predict_normal(tfn_pkg::tfn_item_t t);
    tfn_pkg::tfn_result_t r;
    logic signed [33:0] e1 [3];
    logic signed [33:0] e2 [3];
    logic signed [127:0] cr [3];
    logic [127:0] mag [3];
    logic [127:0] orv;
    logic [63:0] m [3];
    logic [63:0] sum, sq, len, n;
    logic [63:0] thr;
    bit neg [3];
    bit zero, is_small, degen, sat;
    int unsigned bits, sh;
    e1[0] = 34'(t.bx) - 34'(t.ax);
    e1[1] = 34'(t.by_coord) - 34'(t.ay);
    e1[2] = 34'(t.bz) - 34'(t.az);
    e2[0] = 34'(t.cx) - 34'(t.ax);
    e2[1] = 34'(t.cy) - 34'(t.ay);
    e2[2] = 34'(t.cz) - 34'(t.az);
    cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
    cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
    cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
    zero = 1;
    is_small = 1;
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      if (mag[i] != 0) zero = 0;
      if (mag[i] >= (128'd1 << 32)) is_small = 0;
      orv = orv | mag[i];
    end
    degen = zero;
    if (!zero && is_small) begin
      thr = (64'(min_len_q) * 64'(min_len_q)) << 32;
      sum = 0;
      sat = 0;
      for (int i = 0; i < 3; i++) begin
        sq = mag[i][63:0] * mag[i][63:0];
        if (sum + sq < sum) sat = 1;
        sum = sum + sq;
      end
      if (!sat && sum < thr) degen = 1;
    end
    r.degenerate = degen;
    r.last_out = t.batch_end;
    if (degen) begin
      r.nx = 0;
      r.ny = 0;
      r.nz = tfn_pkg::ONE_Q14;
    end else begin
      bits = 0;
      for (int b = 0; b < 128; b++) if (orv[b]) bits = b + 1;
      sh = bits > 31 ? bits - 31 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = 64'(mag[i] >> sh);
        sum = sum + m[i] * m[i];
      end
      len = root64(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        n = ((m[i] << 15) / len + 1) >> 1;
        if (n > 64'(tfn_pkg::ONE_Q14)) n = 64'(tfn_pkg::ONE_Q14);
        if (neg[i]) n = -n;
        if (i == 0) r.nx = n[15:0];
        else if (i == 1) r.ny = n[15:0];
        else r.nz = n[15:0];
      end
    end
    return r;
  endfunction

  // Result transfers are checked as they appear; the watchdog counts quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_normal(result_o);
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("status: fail");
      $finish;
    end
  end

  // Writes one register through the configuration port.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == tfn_pkg::REG_MIN_LENGTH) min_len_q = value[15:0];
  endtask

  // Sends one triangle after a random gap and records its expected normal.
  task automatic send_triangle(tfn_pkg::tfn_item_t t);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= t;
    do @(posedge clk_i); while (busy);
    board.note_triangle(predict_normal(t));
  endtask

  // Lets the pipeline drain before a register change or the end.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (tfn_pkg::Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord(int unsigned spread);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 2 * spread)) - $signed(spread));
    endcase
  endfunction

  // Random triangle: small, tiny (near-degenerate), collinear or full-range.
  function automatic tfn_pkg::tfn_item_t random_triangle();
    tfn_pkg::tfn_item_t t;
    int unsigned spread;
    int signed k;
    case ($urandom_range(0, 3))
      0: spread = 16;
      1: spread = 1 << 10;
      2: spread = 1 << 20;
      default: spread = 32'h7fff_ffff;
    endcase
    t.ax = pick_coord(spread);
    t.ay = pick_coord(spread);
    t.az = pick_coord(spread);
    t.bx = pick_coord(spread);
    t.by_coord = pick_coord(spread);
    t.bz = pick_coord(spread);
    t.cx = pick_coord(spread);
    t.cy = pick_coord(spread);
    t.cz = pick_coord(spread);
    if ($urandom_range(0, 7) == 0) begin
      // Collinear vertices give a zero cross product.
      k = $urandom_range(0, 3);
      t.cx = t.ax + k * (t.bx - t.ax);
      t.cy = t.ay + k * (t.by_coord - t.ay);
      t.cz = t.az + k * (t.bz - t.az);
    end
    t.batch_end = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic tfn_pkg::tfn_item_t make_tri(
      logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
      logic [31:0] bx, logic [31:0] by_c, logic [31:0] bz,
      logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
      logic last);
    tfn_pkg::tfn_item_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by_coord = by_c; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    t.batch_end = last;
    return t;
  endfunction

  initial begin
    logic [15:0] lens [4];
    lens[0] = 16'd0;
    lens[1] = 16'd1;
    lens[2] = 16'd300;
    lens[3] = 16'hffff;
    idle_cycles = 0;
    timed_out = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed triangles under the reset minimum length.
    send_triangle(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 1'b1));
    send_triangle(make_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 1'b0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_triangle(make_tri(5, 5, 5, 10, 10, 10, 20, 20, 20, 1'b0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
    send_triangle(make_tri(0, 0, 0, 32'h70000, 0, 0, 0, 32'h10000, 0, 1'b1));
    send_triangle(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
    send_triangle(make_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
    send_triangle(make_tri(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 1'b0));
    send_triangle(make_tri(0, 0, 0, 32'h30000, 32'h40000, 0, 0, 0, 32'h10000, 1'b1));
    drain_pipeline();

    // Random phases across several minimum lengths, the extremes among them.
    // The upper data bits carry noise that the register must ignore.
    for (int p = 0; p < 4; p++) begin
      write_reg(tfn_pkg::REG_MIN_LENGTH, {16'($urandom), lens[p]});
      send_triangle(make_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 1'b0));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1));
      for (int i = 0; i < RandomItems / 5; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // A triangle sent with no gap before it, at full rate.
          start <= 1'b1;
          item_i <= random_triangle();
          do @(posedge clk_i); while (busy);
          board.note_triangle(predict_normal(item_i));
        end else begin
          send_triangle(random_triangle());
        end
      end
      drain_pipeline();
    end
    write_reg(tfn_pkg::REG_MIN_LENGTH, $urandom_range(0, 65535));
    for (int i = 0; i < RandomItems / 5; i++) send_triangle(random_triangle());
    drain_pipeline();

    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
